FILE: rtl/running_signal_statistics_core_assert.svh
// Assertion macros for the statistics core checker.
`ifndef RUNNING_SIGNAL_STATISTICS_CORE_ASSERT_SVH
`define RUNNING_SIGNAL_STATISTICS_CORE_ASSERT_SVH

// Checks a property on the core clock, ignored while reset is held.
`define RSSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("statistics core property violated");

// Checks that a condition implies a consequence in the same cycle.
`define RSSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("statistics core implication violated");

`endif

FILE: rtl/rssc_pkg.sv
// Shared types and constants of the running signal statistics core.
package rssc_pkg;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam int DIV_W  = 66;
    localparam int STEP_W = 7;

    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic               idx_ok;
        logic [3:0]         idx;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [31:0]       den;
        logic [31:0]       rem0;
        logic [DIV_W-1:0]  num;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: rtl/rssc_front.sv
// Input side: accepts items, drops those without effect and queues the rest.
module rssc_front import rssc_pkg::*; #(
    parameter int NUM_SIGNALS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_signal_index,
    input  logic signed [31:0] i_sample_value,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_pop
);

    t_item             r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic  w_idx_ok;
    logic  w_keep;
    logic  w_push;
    logic  w_pop;
    t_item w_item;

    assign w_idx_ok = 32'(i_signal_index) < NUM_SIGNALS;
    // A sample for a signal that does not exist and an unknown kind have no effect.
    assign w_keep   = (i_kind == KIND_QUERY) || (i_kind == KIND_CLEAR) ||
                      ((i_kind == KIND_ADD) && w_idx_ok);
    assign w_push   = i_in_valid && !o_in_stall && w_keep;
    assign w_pop    = i_q_pop && (r_cnt != '0);

    assign w_item.op     = i_kind;
    assign w_item.idx_ok = w_idx_ok;
    assign w_item.idx    = i_signal_index;
    assign w_item.value  = i_sample_value;

    assign o_in_stall = (r_cnt == QCNT_W'(QDEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_buf[r_wp] <= w_item;
                r_wp        <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

FILE: rtl/rssc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module rssc_div import rssc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_quo;

    logic [32:0] w_trial;
    logic        w_ge;
    logic [31:0] n_rem;

    // The remainder stays below the divisor, so 32 bits hold it.
    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem0;
                r_den  <= i_req.den;
                r_num  <= i_req.num;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[DIV_W-2:0], 1'b0};
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/rssc_back.sv
// Execution side: statistics stores, sample store, update and query sequencer.
module rssc_back import rssc_pkg::*; #(
    parameter int NUM_SIGNALS  = 16,
    parameter int SAMPLE_LIMIT = 256,
    parameter int NUM_BUCKETS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_sample_count,
    output logic signed [31:0] o_min_value,
    output logic signed [31:0] o_max_value,
    output logic signed [31:0] o_mean_value,
    output logic [30:0]        o_std_dev,
    output logic [3:0]         o_bucket_index,
    output logic [8:0]         o_bucket_hits,
    output logic               o_last
);

    localparam int IW     = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
    localparam int SDEPTH = NUM_SIGNALS * SAMPLE_LIMIT;
    localparam int AW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int SW     = $clog2(SAMPLE_LIMIT + 1);
    localparam int KW     = $clog2(NUM_BUCKETS);
    localparam int QW     = $clog2(NUM_BUCKETS) + 1;
    localparam int DW     = 33 + QW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_AABS   = 5'd2;
    localparam logic [4:0] S_ASTART = 5'd3;
    localparam logic [4:0] S_ADIV   = 5'd4;
    localparam logic [4:0] S_AD2    = 5'd5;
    localparam logic [4:0] S_AABS2  = 5'd6;
    localparam logic [4:0] S_AMUL   = 5'd7;
    localparam logic [4:0] S_AWR    = 5'd8;
    localparam logic [4:0] S_QSTATS = 5'd9;
    localparam logic [4:0] S_QSTART = 5'd10;
    localparam logic [4:0] S_QDIV   = 5'd11;
    localparam logic [4:0] S_QSQRT  = 5'd12;
    localparam logic [4:0] S_HRD    = 5'd13;
    localparam logic [4:0] S_HCALC  = 5'd14;
    localparam logic [4:0] S_HSTART = 5'd15;
    localparam logic [4:0] S_HWAIT  = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    // Per-signal statistics stores.
    logic [31:0]        r_cnt_mem  [NUM_SIGNALS];
    logic [63:0]        r_mean_mem [NUM_SIGNALS];
    logic [63:0]        r_m2_mem   [NUM_SIGNALS];
    logic signed [31:0] r_min_mem  [NUM_SIGNALS];
    logic signed [31:0] r_max_mem  [NUM_SIGNALS];
    logic signed [31:0] r_smp_mem  [SDEPTH];
    logic [NUM_SIGNALS-1:0] r_sig_vld;

    logic [31:0]        r_rd_cnt;
    logic [63:0]        r_rd_mean;
    logic [63:0]        r_rd_m2;
    logic signed [31:0] r_rd_min;
    logic signed [31:0] r_rd_max;
    logic signed [31:0] r_smp;

    logic [4:0]         r_state;
    t_item              r_item;
    logic [31:0]        r_cnt;
    logic [63:0]        r_mean;
    logic [63:0]        r_m2;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic [65:0]        r_x64;
    logic [65:0]        r_delta;
    logic [65:0]        r_delta2;
    logic [65:0]        r_mag;
    logic [63:0]        r_mb;
    logic               r_tz;
    logic [2:0]         r_mstep;
    logic [63:0]        r_pp;
    logic [127:0]       r_acc;
    logic signed [31:0] r_mv;
    logic [30:0]        r_sd;
    logic [63:0]        r_sq_v;
    logic [63:0]        r_sq_res;
    logic [63:0]        r_sq_bit;
    logic [SW-1:0]      r_stored;
    logic [SW-1:0]      r_i;
    logic               r_degen;
    logic [31:0]        r_range;
    logic [DW-1:0]      r_hd;
    logic [8:0]         r_hist [NUM_BUCKETS];
    logic [KW-1:0]      r_k;

    logic               r_out_valid;
    logic [31:0]        r_o_cnt;
    logic signed [31:0] r_o_min;
    logic signed [31:0] r_o_max;
    logic signed [31:0] r_o_mean;
    logic [30:0]        r_o_sd;
    logic [3:0]         r_o_bidx;
    logic [8:0]         r_o_bcnt;
    logic               r_o_last;

    logic               w_pop;
    logic               w_vld;
    logic [31:0]        w_e_cnt;
    logic [63:0]        w_e_mean;
    logic [63:0]        w_e_m2;
    logic signed [31:0] w_e_min;
    logic signed [31:0] w_e_max;
    logic [31:0]        w_n_new;
    logic [65:0]        w_x64;
    logic               w_swr;
    logic [AW-1:0]      w_sbase;
    logic [AW-1:0]      w_swaddr;
    logic [AW-1:0]      w_sraddr;
    logic               w_awr;
    logic [31:0]        w_pa;
    logic [31:0]        w_pb;
    logic [63:0]        w_pp;
    logic [127:0]       w_addend;
    logic [63:0]        w_term;
    logic [64:0]        w_m2sum;
    logic [65:0]        w_mt;
    logic [63:0]        w_sq_sum;
    logic               w_sq_ge;
    logic [63:0]        n_sq_res;
    logic [32:0]        w_range33;
    logic [32:0]        w_off;
    logic [DW-1:0]      w_hd;
    logic [QW-1:0]      w_bq;
    logic [KW-1:0]      w_b;
    logic [KW-1:0]      w_hidx;
    logic [8:0]         w_hcur;
    logic [8:0]         n_hinc;
    logic               w_bump;
    logic [SW-1:0]      w_i_nx;
    logic               w_out_free;
    logic               w_q_ok;

    assign w_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = w_pop;

    // A signal not written since the last clear reads as its reset values.
    assign w_vld    = r_sig_vld[IW'(r_item.idx)] && r_item.idx_ok;
    assign w_e_cnt  = w_vld ? r_rd_cnt : 32'd0;
    assign w_e_mean = w_vld ? r_rd_mean : 64'd0;
    assign w_e_m2   = w_vld ? r_rd_m2 : 64'd0;
    assign w_e_min  = w_vld ? r_rd_min : MIN_RESET;
    assign w_e_max  = w_vld ? r_rd_max : MAX_RESET;
    assign w_n_new  = (w_e_cnt == 32'hFFFF_FFFF) ? w_e_cnt : w_e_cnt + 32'd1;
    assign w_x64    = {{18{r_item.value[31]}}, r_item.value, 16'd0};

    assign w_sbase  = AW'(r_item.idx) * AW'(SAMPLE_LIMIT);
    assign w_swaddr = w_sbase + AW'(w_e_cnt);
    assign w_sraddr = w_sbase + AW'(r_i);
    assign w_swr    = (r_state == S_LOAD) && (r_item.op == KIND_ADD) &&
                      (w_e_cnt < 32'(SAMPLE_LIMIT));
    assign w_awr    = (r_state == S_AWR);

    // M2 term: 64x64 product built from four 32x32 partial products.
    assign w_pa = r_mstep[1] ? r_mag[63:32] : r_mag[31:0];
    assign w_pb = r_mstep[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        case (r_mstep)
            3'd1:      w_addend = {64'd0, r_pp};
            3'd2:      w_addend = {32'd0, r_pp, 32'd0};
            3'd3:      w_addend = {32'd0, r_pp, 32'd0};
            3'd4:      w_addend = {r_pp, 64'd0};
            default:   w_addend = '0;
        endcase
    end

    assign w_term  = r_tz ? 64'd0 :
                     ((r_acc[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : r_acc[95:32]);
    assign w_m2sum = {1'b0, r_m2} + {1'b0, w_term};

    assign w_mt = {{2{r_mean[63]}}, r_mean} + 66'd32768;

    assign w_sq_sum = r_sq_res + r_sq_bit;
    assign w_sq_ge  = r_sq_v >= w_sq_sum;
    assign n_sq_res = w_sq_ge ? ((r_sq_res >> 1) + r_sq_bit) : (r_sq_res >> 1);

    assign w_range33 = {r_max[31], r_max} - {r_min[31], r_min};
    assign w_off     = {r_smp[31], r_smp} - {r_min[31], r_min};
    assign w_hd      = DW'(w_off) * DW'(NUM_BUCKETS);
    assign w_bq      = i_div_rsp.quo[QW-1:0];
    assign w_b       = (w_bq > QW'(NUM_BUCKETS - 1)) ? KW'(NUM_BUCKETS - 1) : KW'(w_bq);
    assign w_i_nx    = r_i + 1'b1;

    always_comb begin
        case (r_state)
            S_HWAIT: w_hidx = w_b;
            S_EMIT:  w_hidx = r_k;
            default: w_hidx = '0;
        endcase
    end

    assign w_hcur  = r_hist[w_hidx];
    assign n_hinc  = (&w_hcur) ? w_hcur : w_hcur + 9'd1;
    assign w_bump  = ((r_state == S_HCALC) && r_degen) ||
                     ((r_state == S_HWAIT) && i_div_rsp.done);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_q_ok     = (r_state == S_EMIT) && w_out_free;

    always_comb begin
        o_div_req = '0;
        case (r_state)
            S_ASTART: begin
                o_div_req.start = 1'b1;
                o_div_req.steps = STEP_W'(DIV_W);
                o_div_req.den   = r_cnt;
                o_div_req.num   = r_mag + DIV_W'(r_cnt >> 1);
            end
            S_QSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.steps = STEP_W'(DIV_W);
                o_div_req.den   = r_cnt - 32'd1;
                o_div_req.num   = DIV_W'(r_m2);
            end
            S_HSTART: begin
                // The quotient is at most the bucket count, so only its low bits run.
                o_div_req.start = 1'b1;
                o_div_req.steps = STEP_W'(QW);
                o_div_req.den   = r_range;
                o_div_req.rem0  = 32'(r_hd >> QW);
                o_div_req.num   = {r_hd[QW-1:0], {(DIV_W - QW){1'b0}}};
            end
            default: o_div_req = '0;
        endcase
    end

    // Statistics stores: one read port at the popped item, one write port.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd_cnt  <= r_cnt_mem[IW'(i_q_item.idx)];
            r_rd_mean <= r_mean_mem[IW'(i_q_item.idx)];
            r_rd_m2   <= r_m2_mem[IW'(i_q_item.idx)];
            r_rd_min  <= r_min_mem[IW'(i_q_item.idx)];
            r_rd_max  <= r_max_mem[IW'(i_q_item.idx)];
        end
        if (w_awr) begin
            r_cnt_mem[IW'(r_item.idx)]  <= r_cnt;
            r_mean_mem[IW'(r_item.idx)] <= r_mean;
            r_m2_mem[IW'(r_item.idx)]   <= w_m2sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF :
                                                         w_m2sum[63:0];
            r_min_mem[IW'(r_item.idx)]  <= (r_item.value < r_min) ? r_item.value : r_min;
            r_max_mem[IW'(r_item.idx)]  <= (r_item.value > r_max) ? r_item.value : r_max;
        end
    end

    // Sample store.
    always_ff @(posedge i_clk) begin
        if (w_swr) begin
            r_smp_mem[w_swaddr] <= r_item.value;
        end
        if (r_state == S_HRD) begin
            r_smp <= r_smp_mem[w_sraddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sig_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loaded in the same cycle keeps the valid high.
            if (r_out_valid && !i_out_stall && !w_q_ok) begin
                r_out_valid <= 1'b0;
            end
            if (w_bump) begin
                r_hist[w_hidx] <= n_hinc;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (i_q_item.op == KIND_CLEAR) begin
                            r_sig_vld <= '0;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_mean <= w_e_mean;
                    r_m2   <= w_e_m2;
                    r_min  <= w_e_min;
                    r_max  <= w_e_max;
                    if (r_item.op == KIND_ADD) begin
                        r_cnt   <= w_n_new;
                        r_x64   <= w_x64;
                        r_delta <= w_x64 - {{2{w_e_mean[63]}}, w_e_mean};
                        r_state <= S_AABS;
                    end else begin
                        r_cnt   <= w_e_cnt;
                        r_state <= S_QSTATS;
                    end
                end
                S_AABS: begin
                    r_mag   <= r_delta[65] ? (~r_delta + 66'd1) : r_delta;
                    r_state <= S_ASTART;
                end
                S_ASTART: begin
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (i_div_rsp.done) begin
                        r_mean  <= r_delta[65] ? (r_mean - i_div_rsp.quo[63:0]) :
                                                 (r_mean + i_div_rsp.quo[63:0]);
                        r_state <= S_AD2;
                    end
                end
                S_AD2: begin
                    r_delta2 <= r_x64 - {{2{r_mean[63]}}, r_mean};
                    r_state  <= S_AABS2;
                end
                S_AABS2: begin
                    r_mb    <= r_delta2[65] ? 64'(~r_delta2 + 66'd1) : r_delta2[63:0];
                    // The term counts only when both deviations are nonzero and agree in sign.
                    r_tz    <= (r_delta == '0) || (r_delta2 == '0) ||
                               (r_delta[65] != r_delta2[65]);
                    r_mstep <= 3'd0;
                    r_acc   <= '0;
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_pp    <= w_pp;
                    r_acc   <= r_acc + w_addend;
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd4) begin
                        r_state <= S_AWR;
                    end
                end
                S_AWR: begin
                    r_sig_vld[IW'(r_item.idx)] <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_QSTATS: begin
                    for (int j = 0; j < NUM_BUCKETS; j++) begin
                        r_hist[j] <= '0;
                    end
                    if (r_cnt == 32'd0) begin
                        r_mv <= '0;
                    end else if (w_mt[65:47] != {19{w_mt[47]}}) begin
                        r_mv <= w_mt[65] ? MAX_RESET : MIN_RESET;
                    end else begin
                        r_mv <= w_mt[47:16];
                    end
                    r_sd     <= '0;
                    r_stored <= (r_cnt < 32'(SAMPLE_LIMIT)) ? SW'(r_cnt) : SW'(SAMPLE_LIMIT);
                    r_i      <= '0;
                    r_k      <= '0;
                    r_degen  <= (r_cnt < 32'd2) || (r_max <= r_min);
                    r_range  <= w_range33[31:0];
                    if (r_cnt >= 32'd2) begin
                        r_state <= S_QSTART;
                    end else if (r_cnt == 32'd1) begin
                        r_state <= S_HRD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_QSTART: begin
                    r_state <= S_QDIV;
                end
                S_QDIV: begin
                    if (i_div_rsp.done) begin
                        r_sq_v   <= i_div_rsp.quo[63:0];
                        r_sq_res <= '0;
                        r_sq_bit <= 64'h4000_0000_0000_0000;
                        r_state  <= S_QSQRT;
                    end
                end
                S_QSQRT: begin
                    // Integer square root, two radicand bits per cycle.
                    if (w_sq_ge) begin
                        r_sq_v <= r_sq_v - w_sq_sum;
                    end
                    r_sq_res <= n_sq_res;
                    r_sq_bit <= r_sq_bit >> 2;
                    if (r_sq_bit == 64'd1) begin
                        r_sd    <= (n_sq_res > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : n_sq_res[30:0];
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HCALC;
                end
                S_HCALC: begin
                    r_hd <= w_hd;
                    if (r_degen) begin
                        r_i     <= w_i_nx;
                        r_state <= (w_i_nx == r_stored) ? S_EMIT : S_HRD;
                    end else begin
                        r_state <= S_HSTART;
                    end
                end
                S_HSTART: begin
                    r_state <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (i_div_rsp.done) begin
                        r_i     <= w_i_nx;
                        r_state <= (w_i_nx == r_stored) ? S_EMIT : S_HRD;
                    end
                end
                S_EMIT: begin
                    if (w_q_ok) begin
                        r_out_valid <= 1'b1;
                        r_o_cnt     <= r_cnt;
                        r_o_min     <= (r_cnt == 32'd0) ? 32'sd0 : r_min;
                        r_o_max     <= (r_cnt == 32'd0) ? 32'sd0 : r_max;
                        r_o_mean    <= r_mv;
                        r_o_sd      <= r_sd;
                        r_o_bidx    <= 4'(r_k);
                        r_o_bcnt    <= w_hcur;
                        r_o_last    <= (r_k == KW'(NUM_BUCKETS - 1));
                        r_k         <= r_k + 1'b1;
                        if (r_k == KW'(NUM_BUCKETS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_o_cnt;
    assign o_min_value    = r_o_min;
    assign o_max_value    = r_o_max;
    assign o_mean_value   = r_o_mean;
    assign o_std_dev      = r_o_sd;
    assign o_bucket_index = r_o_bidx;
    assign o_bucket_hits  = r_o_bcnt;
    assign o_last         = r_o_last;

endmodule

FILE: rtl/running_signal_statistics_core.sv
// Top level of the running signal statistics core.
//
//  channel | direction | handshake                 | fields
//  input   | in        | i_in_valid / o_in_stall   | i_kind, i_signal_index, i_sample_value
//  result  | out       | o_out_valid / i_out_stall | o_sample_count .. o_last
//
// A clear is handled in the idle state of the sequencer. A sample runs the 66-bit serial
// divide of the mean update. A query runs the variance divide and the 32-step square
// root, then for each stored sample a read, a bucket computation and, unless the range
// is degenerate, a divide for the bucket quotient; then it emits one result per bucket.
// Reset is synchronous and needs no clearing pass; a two-entry queue decouples input
// transfers from the sequencer, and a stalled result holds while the queue still fills.
module running_signal_statistics_core import rssc_pkg::*; #(
    parameter int NUM_SIGNALS  = 16,
    parameter int SAMPLE_LIMIT = 256,
    parameter int NUM_BUCKETS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_signal_index,
    input  logic signed [31:0] i_sample_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_sample_count,
    output logic signed [31:0] o_min_value,
    output logic signed [31:0] o_max_value,
    output logic signed [31:0] o_mean_value,
    output logic [30:0]        o_std_dev,
    output logic [3:0]         o_bucket_index,
    output logic [8:0]         o_bucket_hits,
    output logic               o_last
);

    logic     w_q_valid;
    t_item    w_q_item;
    logic     w_q_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    rssc_front #(
        .NUM_SIGNALS(NUM_SIGNALS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_signal_index (i_signal_index),
        .i_sample_value (i_sample_value),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_pop        (w_q_pop)
    );

    rssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rssc_back #(
        .NUM_SIGNALS  (NUM_SIGNALS),
        .SAMPLE_LIMIT (SAMPLE_LIMIT),
        .NUM_BUCKETS  (NUM_BUCKETS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_div_req      (w_div_req),
        .i_div_rsp      (w_div_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_count (o_sample_count),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_bucket_index (o_bucket_index),
        .o_bucket_hits  (o_bucket_hits),
        .o_last         (o_last)
    );

endmodule

FILE: rtl/rssc_checker.sv
// Port-level checker for the statistics core and its bind.
`include "running_signal_statistics_core_assert.svh"

module rssc_checker #(
    parameter int NUM_BUCKETS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [31:0]        o_sample_count,
    input logic signed [31:0] o_min_value,
    input logic signed [31:0] o_max_value,
    input logic [30:0]        o_std_dev,
    input logic [3:0]         o_bucket_index,
    input logic               o_last
);

    // A stalled result holds.
    `RSSC_ASSERT(a_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_count) && $stable(o_bucket_index)))
    // Buckets of one query follow each other without a gap and share the statistics.
    `RSSC_ASSERT(a_next_bucket, (o_out_valid && !i_out_stall && !o_last) |=> (o_out_valid && (o_bucket_index == 4'($past(o_bucket_index) + 4'd1)) && $stable(o_sample_count)))
    `RSSC_ASSERT_IMPL(a_last_index, o_out_valid && o_last, o_bucket_index == 4'(NUM_BUCKETS - 1))
    `RSSC_ASSERT_IMPL(a_sd_few, o_out_valid && (o_sample_count < 32'd2), o_std_dev == 31'd0)
    `RSSC_ASSERT_IMPL(a_min_max, o_out_valid && (o_sample_count != 32'd0), o_min_value <= o_max_value)

endmodule

bind running_signal_statistics_core rssc_checker #(
    .NUM_BUCKETS(NUM_BUCKETS)
) u_rssc_checker (.*);

FILE: bench/stats_checker.sv
// Checker for the statistics core: watches both channels, predicts query results, compares.
`timescale 1ns / 1ps
module stats_checker import rssc_pkg::*; #(
    parameter int NUM_SIGNALS  = 16,
    parameter int SAMPLE_LIMIT = 256,
    parameter int NUM_BUCKETS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_signal_index,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_sample_count,
    input  logic signed [31:0] i_min_value,
    input  logic signed [31:0] i_max_value,
    input  logic signed [31:0] i_mean_value,
    input  logic [30:0]        i_std_dev,
    input  logic [3:0]         i_bucket_index,
    input  logic [8:0]         i_bucket_hits,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);

    typedef struct packed {
        logic [31:0]        cnt;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic signed [31:0] mean;
        logic [30:0]        sd;
        logic [3:0]         bidx;
        logic [8:0]         bcnt;
        logic               last;
    } t_stats_row;

    logic [31:0]        sig_count [NUM_SIGNALS];
    logic signed [63:0] sig_mean  [NUM_SIGNALS];
    logic [63:0]        sig_m2    [NUM_SIGNALS];
    logic signed [31:0] sig_min   [NUM_SIGNALS];
    logic signed [31:0] sig_max   [NUM_SIGNALS];
    logic signed [31:0] sig_hist  [NUM_SIGNALS][SAMPLE_LIMIT];
    t_stats_row         expected_rows[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic clear_all();
        for (int s = 0; s < NUM_SIGNALS; s++) begin
            sig_count[s] = 0;
            sig_mean[s] = 0;
            sig_m2[s] = 0;
            sig_min[s] = MIN_RESET;
            sig_max[s] = MAX_RESET;
        end
    endtask

    task automatic update_signal(int s, logic signed [31:0] x);
        logic [31:0]         n;
        logic signed [63:0]  xw;
        logic signed [63:0]  d1;
        logic signed [63:0]  d2;
        logic [63:0]         mag;
        logic [63:0]         q;
        logic [127:0]        prod;
        logic [63:0]         term;
        logic [64:0]         sum;
        n = sig_count[s];
        if (n < SAMPLE_LIMIT) sig_hist[s][n] = x;
        if (n != 32'hFFFF_FFFF) n++;
        sig_count[s] = n;
        xw = 64'(x) <<< 16;
        d1 = xw - sig_mean[s];
        mag = d1 < 0 ? -d1 : d1;
        q = (mag + 64'(n / 2)) / 64'(n);
        sig_mean[s] = d1 < 0 ? sig_mean[s] - q : sig_mean[s] + q;
        d2 = xw - sig_mean[s];
        term = 0;
        if (d1 != 0 && d2 != 0 && ((d1 < 0) == (d2 < 0))) begin
            prod = 128'(mag) * 128'(d2 < 0 ? -d2 : d2);
            term = (prod[127:96] != 0) ? '1 : prod[95:32];
        end
        sum = 65'(sig_m2[s]) + 65'(term);
        sig_m2[s] = sum[64] ? '1 : sum[63:0];
        if (x < sig_min[s]) sig_min[s] = x;
        if (x > sig_max[s]) sig_max[s] = x;
    endtask

    task automatic predict_query(int s);
        t_stats_row          row;
        int                  hist [NUM_BUCKETS];
        logic [31:0]         n;
        logic signed [63:0]  m;
        logic [63:0]         sd;
        logic [63:0]         b;
        int                  stored;
        n = (s < NUM_SIGNALS) ? sig_count[s] : 0;
        for (int k = 0; k < NUM_BUCKETS; k++) hist[k] = 0;
        row = '0;
        if (n != 0) begin
            m = (sig_mean[s] + 64'sd32768) >>> 16;
            if (m > 64'sh7FFF_FFFF) m = 64'sh7FFF_FFFF;
            if (m < -64'sh8000_0000) m = -64'sh8000_0000;
            row.cnt = n;
            row.mean = m[31:0];
            row.mn = sig_min[s];
            row.mx = sig_max[s];
            if (n >= 2) begin
                sd = int_sqrt(sig_m2[s] / 64'(n - 1));
                row.sd = sd > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : sd[30:0];
            end
            stored = n < SAMPLE_LIMIT ? n : SAMPLE_LIMIT;
            for (int i = 0; i < stored; i++) begin
                b = 0;
                if (n >= 2 && row.mx > row.mn) begin
                    b = 64'(64'(sig_hist[s][i]) - 64'(row.mn)) * NUM_BUCKETS
                        / 64'(64'(row.mx) - 64'(row.mn));
                    if (b > NUM_BUCKETS - 1) b = NUM_BUCKETS - 1;
                end
                hist[b]++;
            end
        end
        for (int k = 0; k < NUM_BUCKETS; k++) begin
            row.bidx = 4'(k);
            row.bcnt = hist[k] > 511 ? 9'd511 : 9'(hist[k]);
            row.last = (k == NUM_BUCKETS - 1);
            expected_rows.push_back(row);
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_pending = 0;
        clear_all();
    end

    always @(posedge i_clk) begin
        t_stats_row exp_row;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            case (i_kind)
                KIND_ADD:   if (i_signal_index < NUM_SIGNALS)
                                update_signal(i_signal_index, i_sample_value);
                KIND_QUERY: predict_query(i_signal_index);
                KIND_CLEAR: clear_all();
                default: ;
            endcase
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_result_count++;
            if (expected_rows.size() == 0) begin
                $error("result transfer with no result expected");
                o_fail_count++;
            end else begin
                exp_row = expected_rows.pop_front();
                check_field("sample_count", exp_row.cnt, i_sample_count);
                check_field("min_value", exp_row.mn, i_min_value);
                check_field("max_value", exp_row.mx, i_max_value);
                check_field("mean_value", exp_row.mean, i_mean_value);
                check_field("std_dev", exp_row.sd, i_std_dev);
                check_field("bucket_index", exp_row.bidx, i_bucket_index);
                check_field("bucket_hits", exp_row.bcnt, i_bucket_hits);
                check_field("last", exp_row.last, i_last);
            end
        end
        o_pending <= expected_rows.size();
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, stimulus with idling phases and the final verdict.
`timescale 1ns / 1ps
module tb_top import rssc_pkg::*; ;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         kind = KIND_CLEAR;
    logic [3:0]         sig_index = 0;
    logic signed [31:0] sample_value = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [31:0]        sample_count;
    logic signed [31:0] min_value, max_value, mean_value;
    logic [30:0]        std_dev;
    logic [3:0]         bucket_index;
    logic [8:0]         bucket_hits;
    logic               last;
    int                 fail_count, pending, result_count;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 idle_cycles = 0;
    int                 item_count = 0;
    int                 query_count = 0;

    always #5 i_clk = ~i_clk;

    running_signal_statistics_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_signal_index(sig_index), .i_sample_value(sample_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_sample_count(sample_count), .o_min_value(min_value), .o_max_value(max_value),
        .o_mean_value(mean_value), .o_std_dev(std_dev), .o_bucket_index(bucket_index),
        .o_bucket_hits(bucket_hits), .o_last(last)
    );

    stats_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_signal_index(sig_index), .i_sample_value(sample_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_sample_count(sample_count), .i_min_value(min_value), .i_max_value(max_value),
        .i_mean_value(mean_value), .i_std_dev(std_dev), .i_bucket_index(bucket_index),
        .i_bucket_hits(bucket_hits), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: counts cycles in which no transfer happens on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one item and holds it until the transfer; valid stays up for a
    // following item unless the sender idles first.
    task automatic send_item(logic [1:0] k, logic [3:0] s, logic signed [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        kind <= k;
        sig_index <= s;
        sample_value <= v;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        item_count++;
        if (k == KIND_QUERY) query_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(2047)) << 16) - 32'sd67108864;
            2: return $signed($urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
            default: return $signed(32'($urandom_range(65535)) - 32'd32768);
        endcase
    endfunction

    initial begin
        int phase_pct [4][2];
        int sig;
        phase_pct = '{'{0, 0}, '{79, 0}, '{0, 79}, '{23, 23}};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty queries, extremes, degenerate cases.
        send_item(KIND_QUERY, 4'd0, 0);
        send_item(KIND_ADD, 4'd15, 32'sh7FFF_FFFF);
        send_item(KIND_QUERY, 4'd15, 0);
        send_item(KIND_ADD, 4'd15, 32'sh8000_0000);
        send_item(KIND_ADD, 4'd15, 32'sh7FFF_FFFF);
        send_item(KIND_ADD, 4'd15, 0);
        send_item(KIND_QUERY, 4'd15, 0);
        send_item(KIND_ADD, 4'd3, 32'sh0001_0000);
        send_item(KIND_ADD, 4'd3, 32'sh0001_0000);
        send_item(KIND_QUERY, 4'd3, 0);
        send_item(KIND_UNKNOWN, 4'd3, 32'sh5555_5555);
        send_item(KIND_ADD, 4'd5, -32'sd1);
        send_item(KIND_ADD, 4'd5, 32'sd1);
        send_item(KIND_ADD, 4'd5, 32'sh2AAA_AAAA);
        send_item(KIND_QUERY, 4'd5, 0);
        // Sender holds off until every expected result has arrived.
        wait_drained();
        send_item(KIND_CLEAR, 4'd0, 0);
        send_item(KIND_QUERY, 4'd15, 0);
        send_item(KIND_QUERY, 4'd5, 0);
        wait_drained();

        // Random phases: mostly sample bursts on a few signals, then queries.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            stall_pct = phase_pct[p][1];
            for (int b = 0; b < 5; b++) begin
                sig = $urandom_range(15);
                repeat ($urandom_range(6)) send_item(KIND_ADD, 4'(sig), rand_value());
                if ($urandom_range(9) == 0)
                    send_item(KIND_CLEAR, 4'($urandom()), $signed($urandom()));
                else if ($urandom_range(9) == 0)
                    send_item(KIND_UNKNOWN, 4'($urandom()), $signed($urandom()));
                send_item(KIND_QUERY, 4'(sig), $signed($urandom()));
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
        wait_drained();

        $display("Run covered %0d input transfers, %0d queries, %0d result transfers.",
                 item_count, query_count, result_count);
        $display("Phases: no idling, sender idle, receiver stalling, and both together.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
